// ----- design/feature_value_statistics_defines.svh -----
// Assertion macros shared by the checker of feature_value_statistics.
`ifndef FEATURE_VALUE_STATISTICS_DEFINES_SVH
`define FEATURE_VALUE_STATISTICS_DEFINES_SVH
// Implication check, reset-gated.
`define FVS_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("check failed");
// Next-cycle implication check, reset-gated.
`define FVS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("check failed");
`endif

// ----- design/fvs_pkg.sv -----
// Package: constants and float helpers for feature_value_statistics.
package fvs_pkg;
    localparam logic [31:0] POS_INF = 32'h7F80_0000;
    localparam logic [31:0] NEG_INF = 32'hFF80_0000;
    localparam logic [31:0] ONE_F   = 32'h3F80_0000;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_FILL   = 2'd2
    } action_t;

    // true when a < b under IEEE ordering; neither is NaN
    function automatic logic f_less(input logic [31:0] a, input logic [31:0] b);
        logic a_zero;
        logic b_zero;
        logic res;
        a_zero = (a[30:0] == 31'd0);
        b_zero = (b[30:0] == 31'd0);
        if (a_zero && b_zero)
            res = 1'b0;
        else if (a[31] != b[31])
            res = a[31];
        else if (a[31])
            res = (a[30:0] > b[30:0]);
        else
            res = (a[30:0] < b[30:0]);
        return res;
    endfunction

    function automatic logic has_fraction(input logic [31:0] b);
        logic [7:0]  e;
        logic [22:0] m;
        logic [22:0] mask;
        logic        res;
        e = b[30:23];
        m = b[22:0];
        mask = 23'h7FFFFF >> (8'd23 - (8'd150 - e));
        if (e == 8'hFF)
            res = 1'b0;
        else if (e == 8'd0)
            res = (m != 23'd0);
        else if (e < 8'd127)
            res = 1'b1;
        else if (e >= 8'd150)
            res = 1'b0;
        else
            res = ((m & mask) != 23'd0);
        return res;
    endfunction
endpackage

// ----- design/feature_value_statistics.sv -----
// Top level: streaming per-feature value statistics.
//
// Input channel: value_bits (IEEE single) and example_index, taken when
// in_valid and in_ready are high together. Output channel: one result word
// per input word, carrying all statistics, handed over on out_valid/out_ready.
// out_valid rises in the cycle after an input is accepted. Throughput is one word
// per cycle: the state update is short combinational logic feeding the result
// register, so a new word is taken every cycle while the result register is
// empty or being drained in the same cycle.
// When the receiver stalls, hold the result; in_ready drops until it is taken,
// so nothing is lost or repeated.
// NaN words leave the state untouched and report accepted = 0.
// Counters saturate at all ones; outputs show their low 32 bits.
// Reset (rst_n low, asynchronous) clears all counters, sets min to +inf,
// max to -inf, the last example to all ones and drops any pending result.
module feature_value_statistics #(
    parameter int COUNT_BITS = 32,
    parameter int INDEX_BITS = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [31:0]             value_bits,
    input  logic [31:0]             example_index,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    accepted,
    output logic [31:0]             seen_count,
    output logic [31:0]             example_count,
    output logic [31:0]             repeat_count,
    output logic [31:0]             zero_count,
    output logic [31:0]             one_count,
    output logic [31:0]             fraction_count,
    output logic [31:0]             min_bits,
    output logic [31:0]             max_bits,
    output logic [1:0]              index_action,
    output logic [31:0]             prefix_last
);
    import fvs_pkg::*;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [INDEX_BITS-1:0] IDX_MAX = '1;

    logic [COUNT_BITS-1:0] seen_reg, seen_next, examples_reg, examples_next;
    logic [COUNT_BITS-1:0] twice_reg, twice_next, zeros_reg, zeros_next;
    logic [COUNT_BITS-1:0] ones_reg, ones_next, frac_reg, frac_next;
    logic [31:0]           min_reg, min_next, max_reg, max_next;
    logic [INDEX_BITS-1:0] last_reg, last_next;
    logic [1:0]            ite_reg, ite_next;   // 0,1,2 and saturate at 3 (3 = many)
    logic                  expl_reg, expl_next;
    logic                  out_valid_reg;
    logic                  acc_reg;
    logic [1:0]            act_reg;
    logic [INDEX_BITS-1:0] prefix_reg;

    logic                  take, is_nan, was_dense, now_dense;
    logic [INDEX_BITS-1:0] ex;
    logic [1:0]            act;
    logic [INDEX_BITS-1:0] prefix;
    logic [COUNT_BITS-1:0] examples_less_one;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

    assign in_ready = !out_valid_reg || out_ready;
    assign take     = in_valid && in_ready;
    assign ex       = example_index[INDEX_BITS-1:0];
    assign is_nan   = (value_bits[30:23] == 8'hFF) && (value_bits[22:0] != 23'd0);

    // in_this_example only matters through "== 2"; keep 1, 2 and "more than 2"
    always_comb
    begin
        seen_next         = seen_reg;
        examples_next     = examples_reg;
        twice_next        = twice_reg;
        zeros_next        = zeros_reg;
        ones_next         = ones_reg;
        frac_next         = frac_reg;
        min_next          = min_reg;
        max_next          = max_reg;
        last_next         = last_reg;
        ite_next          = ite_reg;
        expl_next         = expl_reg;
        act               = ACT_NONE;
        prefix            = '0;
        was_dense         = (seen_reg != '0) && !expl_reg;
        now_dense         = 1'b0;
        examples_less_one = '0;
        if (!is_nan)
        begin
            seen_next = sat_inc(seen_reg);
            if (last_reg != ex)
            begin
                examples_next = sat_inc(examples_reg);
                ite_next      = 2'd1;
            end
            else if (ite_reg != 2'd3)
            begin
                ite_next = ite_reg + 2'd1;
            end
            if (ite_next == 2'd2)
                twice_next = sat_inc(twice_reg);
            if (value_bits[30:0] == 31'd0)
                zeros_next = sat_inc(zeros_reg);
            if (value_bits == ONE_F)
                ones_next = sat_inc(ones_reg);
            if (has_fraction(value_bits))
                frac_next = sat_inc(frac_reg);
            if (f_less(value_bits, min_reg))
                min_next = value_bits;
            if (f_less(max_reg, value_bits))
                max_next = value_bits;
            // dense while the example count minus one (wrapping) equals the index and each value opened a new example
            examples_less_one = examples_next - 1'b1;
            now_dense = (64'(examples_less_one) == 64'(ex))
                        && (seen_next == examples_next);
            if (expl_reg)
                act = ACT_APPEND;
            else if (!now_dense)
            begin
                if (was_dense)
                begin
                    act    = ACT_FILL;
                    prefix = last_reg;
                end
                else
                begin
                    act = ACT_APPEND;
                end
                expl_next = 1'b1;
            end
            last_next = ex;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= '0;
            examples_reg  <= '0;
            twice_reg     <= '0;
            zeros_reg     <= '0;
            ones_reg      <= '0;
            frac_reg      <= '0;
            min_reg       <= POS_INF;
            max_reg       <= NEG_INF;
            last_reg      <= IDX_MAX;
            ite_reg       <= 2'd0;
            expl_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= 1'b0;
            act_reg       <= ACT_NONE;
            prefix_reg    <= '0;
        end
        else
        begin
            if (take)
            begin
                seen_reg     <= seen_next;
                examples_reg <= examples_next;
                twice_reg    <= twice_next;
                zeros_reg    <= zeros_next;
                ones_reg     <= ones_next;
                frac_reg     <= frac_next;
                min_reg      <= min_next;
                max_reg      <= max_next;
                last_reg     <= last_next;
                ite_reg      <= ite_next;
                expl_reg     <= expl_next;
                acc_reg      <= !is_nan;
                act_reg      <= act;
                prefix_reg   <= prefix;
            end
            if (take)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // statistics registers double as the result word: they only move on accept
    assign out_valid         = out_valid_reg;
    assign accepted          = acc_reg;
    assign seen_count        = 32'(seen_reg);
    assign example_count     = 32'(examples_reg);
    assign repeat_count      = 32'(twice_reg);
    assign zero_count        = 32'(zeros_reg);
    assign one_count         = 32'(ones_reg);
    assign fraction_count    = 32'(frac_reg);
    assign min_bits          = min_reg;
    assign max_bits          = max_reg;
    assign index_action      = act_reg;
    assign prefix_last       = 32'(prefix_reg);
endmodule

// ----- design/fvs_checker.sv -----
// Port-level checker for feature_value_statistics, bound to the top level.
`include "feature_value_statistics_defines.svh"
module fvs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        accepted,
    input logic [1:0]  index_action,
    input logic [31:0] prefix_last,
    input logic [31:0] seen_count
);
    import fvs_pkg::*;

    `FVS_ASSERT_NEXT(a_one_result, clk, rst_n, in_valid && in_ready, out_valid)
    `FVS_ASSERT_IMP(a_nan_quiet, clk, rst_n, out_valid && !accepted,
        index_action == ACT_NONE)
    `FVS_ASSERT_IMP(a_prefix_zero, clk, rst_n, out_valid && index_action != ACT_FILL,
        prefix_last == 32'd0)
    `FVS_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(seen_count))
endmodule

bind feature_value_statistics fvs_checker u_fvs_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .accepted(accepted),
    .index_action(index_action), .prefix_last(prefix_last),
    .seen_count(seen_count)
);
